/* design/abtrp_pkg.sv */
// Shared types and constants for the absolute-to-relative pointer converter.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package abtrp_pkg;

   // Field widths
   localparam int CoordW = 16;
   localparam int PosW   = 17;
   localparam int DataW  = 40;

   // Command classes decided by the front end
   localparam logic [1:0] CLS_PASS = 2'd0;
   localparam logic [1:0] CLS_ABS  = 2'd1;
   localparam logic [1:0] CLS_TICK = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_PASS = 2'd0;
   localparam logic [1:0] KIND_REL  = 2'd1;
   localparam logic [1:0] KIND_ABS  = 2'd2;

   // Register indexes
   localparam logic [2:0] REG_MODE        = 3'd0;
   localparam logic [2:0] REG_X_BOUNDS    = 3'd1;
   localparam logic [2:0] REG_Y_BOUNDS    = 3'd2;
   localparam logic [2:0] REG_GAIN_X      = 3'd3;
   localparam logic [2:0] REG_GAIN_Y      = 3'd4;
   localparam logic [2:0] REG_SPEED_START = 3'd5;
   localparam logic [2:0] REG_SPEED_END   = 3'd6;
   localparam logic [2:0] REG_SPEED_STEP  = 3'd7;

   // Reset values
   localparam logic [31:0] BOUNDS_RST      = 32'hFFFF_0000;
   localparam logic [23:0] GAIN_RST        = 24'h10_0000;
   localparam logic [14:0] SPEED_START_RST = 15'd50;
   localparam logic [14:0] SPEED_END_RST   = 15'd30;
   localparam logic [14:0] SPEED_STEP_RST  = 15'd30;
   localparam logic [15:0] CENTER_POS      = 16'd32767;

   typedef struct packed {
      logic        mode;
      logic [31:0] x_bounds;
      logic [31:0] y_bounds;
      logic [23:0] gain_x;
      logic [23:0] gain_y;
      logic [14:0] speed_start;
      logic [14:0] speed_end;
      logic [14:0] speed_step;
   } cfg_type;

   // One classified command waiting for the back end
   typedef struct packed {
      logic [1:0]        cls;
      logic [PosW-1:0]   raw_x;
      logic [PosW-1:0]   raw_y;
      logic [CoordW-1:0] abs_x;
      logic [CoordW-1:0] abs_y;
   } cmd_type;

endpackage

`default_nettype wire

/* design/absolute_to_relative_pointer.sv */
// Top level of the absolute-to-relative pointer converter: configuration registers,
// front end, command queue and back end. Depends on abtrp_pkg and the abtrp_* modules.
//
// Turns absolute pointer events into a relative move followed by the original event;
// relative events pass straight through and timer ticks may push at the screen edges.
// The back end emits one result for a relative event or an edge-hitting tick and two for
// an absolute event, all through the single result register; the front end accepts one
// transaction per cycle while the command queue (QUEUE_DEPTH entries) has room. An input
// passes through a queue entry and then the result register. Configuration is to be
// written only while the block is idle; the block itself does not enforce it.
`default_nettype none

module absolute_to_relative_pointer
   import abtrp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)(
   input  wire logic             clock,
   input  wire logic             reset,
   // Input channel
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [DataW-1:0] req_tdata,   // pos_x[16:0], pos_y[33:17], zero pad
   input  wire logic [1:0]       req_tuser,   // func[0], is_absolute[1]
   // Result channel
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [DataW-1:0]      rsp_tdata,   // out_x[16:0], out_y[33:17], zero pad
   output logic [1:0]            rsp_tuser,   // kind[1:0]
   output logic                  rsp_tlast,   // last_of_run
   // Configuration port
   input  wire logic             csr_we,
   input  wire logic [2:0]       csr_index,
   input  wire logic [31:0]      csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   cmd_type push_cmd, head_cmd;
   logic    q_ready, q_push, q_pop, head_valid;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MODE:        cfg_in.mode        = csr_wdata[0];
            REG_X_BOUNDS:    cfg_in.x_bounds    = csr_wdata;
            REG_Y_BOUNDS:    cfg_in.y_bounds    = csr_wdata;
            REG_GAIN_X:      cfg_in.gain_x      = csr_wdata[23:0];
            REG_GAIN_Y:      cfg_in.gain_y      = csr_wdata[23:0];
            REG_SPEED_START: cfg_in.speed_start = csr_wdata[14:0];
            REG_SPEED_END:   cfg_in.speed_end   = csr_wdata[14:0];
            REG_SPEED_STEP:  cfg_in.speed_step  = csr_wdata[14:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode        <= 1'b0;
         cfg_ff.x_bounds    <= BOUNDS_RST;
         cfg_ff.y_bounds    <= BOUNDS_RST;
         cfg_ff.gain_x      <= GAIN_RST;
         cfg_ff.gain_y      <= GAIN_RST;
         cfg_ff.speed_start <= SPEED_START_RST;
         cfg_ff.speed_end   <= SPEED_END_RST;
         cfg_ff.speed_step  <= SPEED_STEP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   abtrp_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .mode       (cfg_ff.mode),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   abtrp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .ready      (q_ready),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   abtrp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

/* design/abtrp_front.sv */
// Front end: accepts input transactions, classifies them and clamps coordinates.
// Depends on abtrp_pkg; feeds abtrp_queue.
`default_nettype none

module abtrp_front
   import abtrp_pkg::*;
(
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [DataW-1:0] req_tdata,
   input  wire logic [1:0]       req_tuser,
   input  wire logic             mode,
   input  wire logic             q_ready,
   output logic                  q_push,
   output cmd_type               q_cmd
);

   logic                     func;
   logic                     is_abs;
   logic signed [PosW-1:0]   pos_x;
   logic signed [PosW-1:0]   pos_y;

   assign func   = req_tuser[0];
   assign is_abs = req_tuser[1];
   assign pos_x  = req_tdata[PosW-1:0];
   assign pos_y  = req_tdata[2*PosW-1:PosW];

   // Accept whenever the queue has room; drop ticks that mode 0 ignores
   assign req_tready = q_ready;
   assign q_push     = req_tvalid && q_ready && !(func && !mode);

   // Classify and clamp negatives to zero (upper clamp is implicit in 17 bits)
   always_comb begin
      if (func) begin
         q_cmd.cls = CLS_TICK;
      end else if (is_abs) begin
         q_cmd.cls = CLS_ABS;
      end else begin
         q_cmd.cls = CLS_PASS;
      end
      q_cmd.raw_x = pos_x;
      q_cmd.raw_y = pos_y;
      q_cmd.abs_x = pos_x[PosW-1] ? '0 : pos_x[CoordW-1:0];
      q_cmd.abs_y = pos_y[PosW-1] ? '0 : pos_y[CoordW-1:0];
   end

endmodule

`default_nettype wire

/* design/abtrp_queue.sv */
// Short command queue between the front end and the back end.
// Depends on abtrp_pkg for the command type.
`default_nettype none

module abtrp_queue
   import abtrp_pkg::*;
#(
   parameter int DEPTH = 2
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         ready,
   input  wire logic    pop,
   output logic         head_valid,
   output cmd_type      head_cmd
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   cmd_type         entry_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff,  count_in;
   logic            do_push, do_pop;

   assign ready      = count_ff != FullCnt;
   assign head_valid = count_ff != '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && ready;
   assign do_pop     = pop && head_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

/* design/abtrp_back.sv */
// Back end: executes queued commands, holds pointer state, drives the result register.
// Depends on abtrp_pkg; fed by abtrp_queue.
`default_nettype none

module abtrp_back
   import abtrp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   input  wire logic             head_valid,
   input  wire cmd_type          head_cmd,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [DataW-1:0]      rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   localparam logic PH_REL = 1'b0;
   localparam logic PH_ABS = 1'b1;

   typedef struct packed {
      logic            hit;
      logic [PosW-1:0] val;
   } push_type;

   // (cur - prev) * gain >> 20, truncated toward zero, saturated to 16 bits
   function automatic logic [PosW-1:0] scale_delta(input logic [CoordW-1:0] cur,
                                                   input logic [CoordW-1:0] prev,
                                                   input logic [23:0]       gain);
      logic            neg;
      logic [15:0]     mag;
      logic [39:0]     prod;
      logic [19:0]     q;
      logic [PosW-1:0] r;
      neg  = cur < prev;
      mag  = neg ? prev - cur : cur - prev;
      prod = {24'd0, mag} * {16'd0, gain};
      q    = prod[39:20];
      if (neg) begin
         r = (q > 20'd32768) ? 17'h18000 : 17'd0 - {1'b0, q[15:0]};
      end else begin
         r = (q > 20'd32767) ? 17'd32767 : {1'b0, q[15:0]};
      end
      return r;
   endfunction

   // Edge check on one axis; the maximum edge wins
   function automatic push_type edge_push(input logic [CoordW-1:0] c,
                                          input logic [31:0]       bounds,
                                          input logic [15:0]       spd,
                                          input logic [PosW-1:0]   dflt);
      push_type p;
      logic     hit_lo, hit_hi;
      hit_lo = c <= bounds[15:0];
      hit_hi = c >= bounds[31:16];
      p.hit  = hit_lo || hit_hi;
      if (hit_hi) begin
         p.val = {1'b0, spd};
      end else if (hit_lo) begin
         p.val = 17'd0 - {1'b0, spd};
      end else begin
         p.val = dflt;
      end
      return p;
   endfunction

   logic              phase_ff,  phase_in;
   logic [CoordW-1:0] prev_x_ff, prev_x_in;
   logic [CoordW-1:0] prev_y_ff, prev_y_in;
   logic [15:0]       speed_ff,  speed_in;
   logic              valid_ff,  valid_in;
   logic [1:0]        kind_ff,   kind_in;
   logic [PosW-1:0]   x_ff,      x_in;
   logic [PosW-1:0]   y_ff,      y_in;
   logic              last_ff,   last_in;
   logic              load;
   logic              out_free;

   logic [PosW-1:0]   delta_x, delta_y;
   push_type          abs_px, abs_py, tick_px, tick_py;
   logic [15:0]       ramp_sum, ramp_next;

   assign out_free = !valid_ff || rsp_tready;

   // Scaled deltas and edge overrides for absolute events
   assign delta_x = scale_delta(head_cmd.abs_x, prev_x_ff, cfg.gain_x);
   assign delta_y = scale_delta(head_cmd.abs_y, prev_y_ff, cfg.gain_y);
   assign abs_px  = edge_push(head_cmd.abs_x, cfg.x_bounds, {1'b0, cfg.speed_start}, delta_x);
   assign abs_py  = edge_push(head_cmd.abs_y, cfg.y_bounds, {1'b0, cfg.speed_start}, delta_y);

   // Edge push for ticks, from the last absolute position
   assign tick_px   = edge_push(prev_x_ff, cfg.x_bounds, speed_ff, '0);
   assign tick_py   = edge_push(prev_y_ff, cfg.y_bounds, speed_ff, '0);
   assign ramp_sum  = speed_ff + {1'b0, cfg.speed_step};
   assign ramp_next = (ramp_sum < {1'b0, cfg.speed_end}) ? ramp_sum : {1'b0, cfg.speed_end};

   // Command sequencing
   always_comb begin
      pop       = 1'b0;
      load      = 1'b0;
      phase_in  = phase_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      speed_in  = speed_ff;
      kind_in   = KIND_PASS;
      x_in      = head_cmd.raw_x;
      y_in      = head_cmd.raw_y;
      last_in   = 1'b1;
      if (head_valid) begin
         unique case (head_cmd.cls)
            CLS_PASS: begin
               if (out_free) begin
                  load = 1'b1;
                  pop  = 1'b1;
               end
            end
            CLS_ABS: begin
               if (out_free) begin
                  load = 1'b1;
                  if (phase_ff == PH_REL) begin
                     kind_in   = KIND_REL;
                     x_in      = cfg.mode ? delta_x : abs_px.val;
                     y_in      = cfg.mode ? delta_y : abs_py.val;
                     last_in   = 1'b0;
                     prev_x_in = head_cmd.abs_x;
                     prev_y_in = head_cmd.abs_y;
                     phase_in  = PH_ABS;
                  end else begin
                     kind_in  = KIND_ABS;
                     pop      = 1'b1;
                     phase_in = PH_REL;
                  end
               end
            end
            CLS_TICK: begin
               if (!(tick_px.hit || tick_py.hit)) begin
                  speed_in = {1'b0, cfg.speed_start};
                  pop      = 1'b1;
               end else if (out_free) begin
                  load     = 1'b1;
                  kind_in  = KIND_REL;
                  x_in     = tick_px.val;
                  y_in     = tick_py.val;
                  speed_in = ramp_next;
                  pop      = 1'b1;
               end
            end
            default: begin
               pop = 1'b1;
            end
         endcase
      end
   end

   // Hold the result until taken
   assign valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_REL;
         prev_x_ff <= CENTER_POS;
         prev_y_ff <= CENTER_POS;
         speed_ff  <= {1'b0, SPEED_START_RST};
         valid_ff  <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         speed_ff  <= speed_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= kind_in;
         x_ff    <= x_in;
         y_ff    <= y_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {{(DataW - 2*PosW){1'b0}}, y_ff, x_ff};

endmodule

`default_nettype wire

/* design/abtrp_checker.sv */
// Port-level checks for the absolute-to-relative pointer converter, bound to the top level.
// Depends on abtrp_pkg for the result kind codes.
`default_nettype none

module abtrp_checker
   import abtrp_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [DataW-1:0] rsp_tdata,
   input wire logic [1:0]       rsp_tuser,
   input wire logic             rsp_tlast
);

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // A relative move that is not last is followed at once by the absolute event
   a_rel_then_abs: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser == KIND_REL && !rsp_tlast
      |=> rsp_tvalid && rsp_tuser == KIND_ABS)
      else $error("absolute event did not follow its relative move");

   // Pass-through and absolute results always close their run
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_PASS || rsp_tuser == KIND_ABS) |-> rsp_tlast)
      else $error("final result of a run without tlast");

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind absolute_to_relative_pointer abtrp_checker u_abtrp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

/* tb/absolute_to_relative_pointer_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for absolute_to_relative_pointer: a scoreboard class predicts each
// result from the accepted input transactions and checks the result stream against it.
// Depends on abtrp_pkg and the absolute_to_relative_pointer design.

module absolute_to_relative_pointer_tb;
   import abtrp_pkg::*;

   localparam int CLK_HALF        = 5;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int SETTLE_CYCLES   = 8;
   localparam int LONG_STALL      = 300;
   localparam int STALL_LIMIT     = 5000;

   // Input codes
   localparam logic FUNC_EVENT = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;
   localparam logic POS_REL    = 1'b0;
   localparam logic POS_ABS    = 1'b1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [16:0] x;
      logic [16:0] y;
      logic        last;
   } pointer_result_type;

   // Predicts pointer results and holds them until the block emits them
   class pointer_scoreboard;
      cfg_type            regs;
      logic [15:0]        last_x;
      logic [15:0]        last_y;
      int unsigned        push_speed;
      pointer_result_type due_q[$];
      int                 errors;

      function new();
         regs.mode        = 1'b0;
         regs.x_bounds    = BOUNDS_RST;
         regs.y_bounds    = BOUNDS_RST;
         regs.gain_x      = GAIN_RST;
         regs.gain_y      = GAIN_RST;
         regs.speed_start = SPEED_START_RST;
         regs.speed_end   = SPEED_END_RST;
         regs.speed_step  = SPEED_STEP_RST;
         last_x           = CENTER_POS;
         last_y           = CENTER_POS;
         push_speed       = SPEED_START_RST;
         errors           = 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [31:0] value);
         case (index)
            REG_MODE:        regs.mode        = value[0];
            REG_X_BOUNDS:    regs.x_bounds    = value;
            REG_Y_BOUNDS:    regs.y_bounds    = value;
            REG_GAIN_X:      regs.gain_x      = value[23:0];
            REG_GAIN_Y:      regs.gain_y      = value[23:0];
            REG_SPEED_START: regs.speed_start = value[14:0];
            REG_SPEED_END:   regs.speed_end   = value[14:0];
            REG_SPEED_STEP:  regs.speed_step  = value[14:0];
            default: ;
         endcase
      endfunction

      function int outstanding();
         return due_q.size();
      endfunction

      // Negative coordinates clamp to zero; the field cannot exceed 65535
      function logic [15:0] clamp(logic [16:0] v);
         return v[16] ? 16'd0 : v[15:0];
      endfunction

      // Scale the delta by a Q4.20 gain, truncate toward zero, saturate to 16 bits
      function int scale_delta(logic [15:0] cur, logic [15:0] prev, logic [23:0] gain);
         longint unsigned mag;
         longint unsigned q;
         if (cur < prev) begin
            mag = prev - cur;
            q   = (mag * gain) >> 20;
            return (q > 32768) ? -32768 : -int'(q);
         end
         mag = cur - prev;
         q   = (mag * gain) >> 20;
         return (q > 32767) ? 32767 : int'(q);
      endfunction

      // Force the axis to the edge speed on a bound; the maximum edge wins
      function bit push_axis(logic [15:0] c, logic [31:0] bounds, int spd, inout int d);
         bit hit;
         hit = 1'b0;
         if (c <= bounds[15:0]) begin
            d   = -spd;
            hit = 1'b1;
         end
         if (c >= bounds[31:16]) begin
            d   = spd;
            hit = 1'b1;
         end
         return hit;
      endfunction

      function void queue_result(logic [1:0] kind, logic [16:0] x, logic [16:0] y, logic last);
         pointer_result_type r;
         r.kind = kind;
         r.x    = x;
         r.y    = y;
         r.last = last;
         due_q.push_back(r);
      endfunction

      function void note_item(logic func, logic absf, logic [16:0] px, logic [16:0] py);
         int          dx;
         int          dy;
         bit          hx;
         bit          hy;
         logic [15:0] cx;
         logic [15:0] cy;
         int unsigned ns;
         dx = 0;
         dy = 0;
         if (func == FUNC_TICK) begin
            // Ticks only act in mode 1, pushing from the last absolute position
            if (regs.mode == 1'b0)
               return;
            hx = push_axis(last_x, regs.x_bounds, push_speed, dx);
            hy = push_axis(last_y, regs.y_bounds, push_speed, dy);
            if (!(hx || hy)) begin
               push_speed = regs.speed_start;
               return;
            end
            queue_result(KIND_REL, 17'(dx), 17'(dy), 1'b1);
            ns         = push_speed + regs.speed_step;
            push_speed = (ns < regs.speed_end) ? ns : regs.speed_end;
         end else if (absf == POS_REL) begin
            queue_result(KIND_PASS, px, py, 1'b1);
         end else begin
            cx = clamp(px);
            cy = clamp(py);
            dx = scale_delta(cx, last_x, regs.gain_x);
            dy = scale_delta(cy, last_y, regs.gain_y);
            if (regs.mode == 1'b0) begin
               void'(push_axis(cx, regs.x_bounds, regs.speed_start, dx));
               void'(push_axis(cy, regs.y_bounds, regs.speed_start, dy));
            end
            queue_result(KIND_REL, 17'(dx), 17'(dy), 1'b0);
            queue_result(KIND_ABS, px, py, 1'b1);
            last_x = cx;
            last_y = cy;
         end
      endfunction

      function void check_result(logic [1:0] kind, logic [16:0] x, logic [16:0] y, logic last);
         pointer_result_type want;
         if (due_q.size() == 0) begin
            $error("result with nothing expected: kind %0d x %0d y %0d",
                   kind, $signed(x), $signed(y));
            errors++;
            return;
         end
         want = due_q.pop_front();
         if (kind !== want.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", want.kind, kind);
            errors++;
         end
         if (x !== want.x) begin
            $error("out_x mismatch: expected %0d, actual %0d", $signed(want.x), $signed(x));
            errors++;
         end
         if (y !== want.y) begin
            $error("out_y mismatch: expected %0d, actual %0d", $signed(want.y), $signed(y));
            errors++;
         end
         if (last !== want.last) begin
            $error("last_of_run mismatch: expected %0d, actual %0d", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [DataW-1:0] req_tdata  = '0;   // pos_x[16:0], pos_y[33:17], zero pad
   logic [1:0]       req_tuser  = '0;   // func[0], is_absolute[1]
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [DataW-1:0] rsp_tdata;         // out_x[16:0], out_y[33:17], zero pad
   logic [1:0]       rsp_tuser;         // kind[1:0]
   logic             rsp_tlast;
   logic             csr_we     = 1'b0;
   logic [2:0]       csr_index  = REG_MODE;
   logic [31:0]      csr_wdata  = '0;

   pointer_scoreboard sb = new();
   int                send_idle_pct  = 25;
   int                recv_idle_pct  = 53;
   bit                long_stall_req = 1'b0;
   int                idle_cycles    = 0;

   absolute_to_relative_pointer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #CLK_HALF clock = ~clock;

   // Offer one input transaction, idling at random first; note it once accepted
   task automatic send_item(logic func, logic absf, logic [16:0] px, logic [16:0] py);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DataW'({py, px});
      req_tuser  <= {absf, func};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sb.note_item(func, absf, px, py);
   endtask

   // Drop the input and hold until every expected result is out and the pipe has drained
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] index, logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(index, value);
   endtask

   // Write the full register set while the block is idle
   task automatic apply_settings(cfg_type c);
      wait_quiet();
      csr_write(REG_MODE,        32'(c.mode));
      csr_write(REG_X_BOUNDS,    c.x_bounds);
      csr_write(REG_Y_BOUNDS,    c.y_bounds);
      csr_write(REG_GAIN_X,      32'(c.gain_x));
      csr_write(REG_GAIN_Y,      32'(c.gain_y));
      csr_write(REG_SPEED_START, 32'(c.speed_start));
      csr_write(REG_SPEED_END,   32'(c.speed_end));
      csr_write(REG_SPEED_STEP,  32'(c.speed_step));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Coordinates lean towards the edges so that edge pushes happen often
   function automatic logic [16:0] pick_coord();
      case ($urandom_range(3))
         0:       return 17'($urandom);
         1:       return 17'($urandom_range(0, 3000));
         2:       return 17'($urandom_range(62535, 65535));
         default: return 17'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [31:0] pick_bounds();
      case ($urandom_range(3))
         0:       return $urandom;
         1:       return {16'($urandom_range(61000, 65535)), 16'($urandom_range(0, 4000))};
         2:       return BOUNDS_RST;
         default: return 32'h0000_FFFF;
      endcase
   endfunction

   function automatic logic [23:0] pick_gain();
      case ($urandom_range(3))
         0:       return 24'hFF_FFFF;
         1:       return 24'h00_0000;
         2:       return 24'($urandom_range(24'h08_0000, 24'h20_0000));
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [14:0] pick_speed();
      case ($urandom_range(3))
         0:       return 15'd0;
         1:       return 15'h7FFF;
         2:       return 15'($urandom);
         default: return 15'($urandom_range(0, 300));
      endcase
   endfunction

   // Result side: check each accepted transaction, stall at random or for a long stretch
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tuser, rsp_tdata[16:0], rsp_tdata[33:17], rsp_tlast);
         if (long_stall_req) begin
            long_stall_req = 1'b0;
            stall_left     = LONG_STALL;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: give up when nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      cfg_type c;
      int      p;
      int      i;
      int      pick;

      c.mode        = 1'b0;
      c.x_bounds    = BOUNDS_RST;
      c.y_bounds    = BOUNDS_RST;
      c.gain_x      = GAIN_RST;
      c.gain_y      = GAIN_RST;
      c.speed_start = SPEED_START_RST;
      c.speed_end   = SPEED_END_RST;
      c.speed_step  = SPEED_STEP_RST;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: pass-through extremes, edge pushes, clamping, ignored ticks
      send_item(FUNC_EVENT, POS_REL, 17'h00000, 17'h00000);
      send_item(FUNC_EVENT, POS_REL, 17'h10000, 17'h0FFFF);
      send_item(FUNC_EVENT, POS_REL, 17'h0FFFF, 17'h10000);
      send_item(FUNC_EVENT, POS_ABS, 17'd32767, 17'd32767);
      send_item(FUNC_EVENT, POS_ABS, 17'd0, 17'd65535);
      send_item(FUNC_EVENT, POS_ABS, 17'h10000, 17'h1FFFF);
      send_item(FUNC_EVENT, POS_ABS, 17'd65535, 17'd65535);
      send_item(FUNC_TICK, POS_REL, 17'h1FFFF, 17'h00000);
      send_item(FUNC_TICK, POS_ABS, 17'h00000, 17'h1FFFF);

      // Mode 1 with a ramp that climbs to its clamp; saturating gains
      c.mode        = 1'b1;
      c.x_bounds    = {16'd60000, 16'd100};
      c.y_bounds    = BOUNDS_RST;
      c.gain_x      = 24'hFF_FFFF;
      c.gain_y      = 24'h00_0000;
      c.speed_start = 15'd40;
      c.speed_end   = 15'd100;
      c.speed_step  = 15'd25;
      apply_settings(c);
      send_item(FUNC_EVENT, POS_ABS, 17'd0, 17'd30000);
      repeat (4) send_item(FUNC_TICK, POS_REL, 17'd0, 17'd0);
      send_item(FUNC_EVENT, POS_ABS, 17'd65535, 17'd65535);
      send_item(FUNC_TICK, POS_REL, 17'd0, 17'd0);
      send_item(FUNC_EVENT, POS_ABS, 17'd30000, 17'd30000);
      send_item(FUNC_TICK, POS_REL, 17'd0, 17'd0);
      send_item(FUNC_TICK, POS_ABS, 17'd0, 17'd0);

      // Both edges of one axis at once; new start speed waits for a reload
      c.x_bounds    = {16'd20000, 16'd40000};
      c.speed_start = 15'h7FFF;
      c.speed_end   = 15'd0;
      c.speed_step  = 15'h7FFF;
      apply_settings(c);
      send_item(FUNC_EVENT, POS_ABS, 17'd30000, 17'd0);
      send_item(FUNC_TICK, POS_REL, 17'd0, 17'd0);

      // Start speed above the end clamp: first push at start, later ones at end
      c.x_bounds = BOUNDS_RST;
      apply_settings(c);
      send_item(FUNC_EVENT, POS_ABS, 17'd30000, 17'd30000);
      send_item(FUNC_TICK, POS_REL, 17'd0, 17'd0);
      send_item(FUNC_EVENT, POS_ABS, 17'd0, 17'd0);
      repeat (2) send_item(FUNC_TICK, POS_REL, 17'd0, 17'd0);

      // Random phases, each under fresh settings
      for (p = 0; p < PHASES; p++) begin
         if (p < 3) begin
            send_idle_pct = 25;
            recv_idle_pct = 53;
         end else if (p < 6) begin
            send_idle_pct = 53;
            recv_idle_pct = 25;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         c.mode        = 1'($urandom);
         c.x_bounds    = pick_bounds();
         c.y_bounds    = pick_bounds();
         c.gain_x      = pick_gain();
         c.gain_y      = pick_gain();
         c.speed_start = pick_speed();
         c.speed_end   = pick_speed();
         c.speed_step  = pick_speed();
         if (p == 1) begin
            c.gain_x      = 24'hFF_FFFF;
            c.gain_y      = 24'hFF_FFFF;
            c.speed_start = 15'h7FFF;
            c.speed_end   = 15'h7FFF;
            c.speed_step  = 15'h7FFF;
         end else if (p == 4) begin
            c.x_bounds    = 32'h0000_0000;
            c.y_bounds    = 32'h0000_0000;
            c.gain_x      = 24'h00_0000;
            c.gain_y      = 24'h00_0000;
            c.speed_start = 15'd0;
            c.speed_end   = 15'd0;
            c.speed_step  = 15'd0;
         end
         apply_settings(c);

         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            // Hold the result side off for a long stretch while input keeps coming
            if (p == 0 && i == 50)
               long_stall_req = 1'b1;
            // Pause the input until the block has emptied
            if (p == 1 && i == 100)
               wait_quiet();
            pick = $urandom_range(99);
            if (pick < 45)
               send_item(FUNC_EVENT, POS_ABS, pick_coord(), pick_coord());
            else if (pick < 70)
               send_item(FUNC_TICK, 1'($urandom), 17'($urandom), 17'($urandom));
            else if (pick < 90)
               send_item(FUNC_EVENT, POS_REL, 17'($urandom), 17'($urandom));
            else
               send_item(1'($urandom), 1'($urandom), 17'($urandom), 17'($urandom));
         end
      end

      wait_quiet();
      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
